// File: rtl/maes_pkg.sv
// Package for the masked AES-128 encryption unit: S-box table, GF helpers,
// sequencer state type. No dependencies.
package maes_pkg;

  localparam logic [7:0] GF_POLY = 8'h1B;
  localparam logic [7:0] AFFINE_C = 8'h63;
  localparam logic [7:0] RCON_FIRST = 8'h01;
  localparam int unsigned NUM_ROUNDS = 10;
  localparam int unsigned ROUND_W = 4;

  typedef enum logic [1:0] {ST_IDLE, ST_ROUND, ST_DONE} state_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
    8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
    8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
    8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
    8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
    8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
    8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
    8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
    8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
    8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
    8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
    8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
    8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
    8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
    8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
    8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
  };

  // multiply by x in GF(2^8)
  function automatic logic [7:0] gf_dbl(input logic [7:0] a);
    return a[7] ? ({a[6:0], 1'b0} ^ GF_POLY) : {a[6:0], 1'b0};
  endfunction

  // MixColumns on one column, row 0 in the top byte
  function automatic logic [31:0] mix_col(input logic [31:0] v);
    logic [7:0] a, b, c, d;
    a = v[31:24]; b = v[23:16]; c = v[15:8]; d = v[7:0];
    return {gf_dbl(a) ^ gf_dbl(b) ^ b ^ c ^ d,
            a ^ gf_dbl(b) ^ gf_dbl(c) ^ c ^ d,
            a ^ b ^ gf_dbl(c) ^ gf_dbl(d) ^ d,
            gf_dbl(a) ^ a ^ b ^ c ^ gf_dbl(d)};
  endfunction

endpackage

// File: rtl/maes_if.sv
// Valid/ready channel interface with a generic payload.
// Depends on nothing.
interface maes_if #(parameter int unsigned W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/maes_round.sv
// Masked AES round unit with on-the-fly key expansion, shared by all rounds.
// Depends on maes_pkg.
module maes_round import maes_pkg::*; (
  input  logic [127:0] state_i,
  input  logic [127:0] key_i,
  input  logic [7:0]   rcon_i,
  input  logic         last_i,
  input  logic [7:0]   m_i,
  input  logic [7:0]   mo_i,
  input  logic [31:0]  rm_i,
  input  logic [31:0]  cm_i,
  output logic [127:0] state_o,
  output logic [127:0] key_o
);
  logic [7:0] sb [16];
  logic [7:0] sr [16];
  logic [7:0] kb [16];
  logic [7:0] nk [16];
  logic [127:0] mixed;

  // masked S-box then shift rows; byte 0 in top bits
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      sb[i] = SBOX[state_i[127-8*i -: 8] ^ m_i] ^ mo_i;
      kb[i] = key_i[127-8*i -: 8];
    end
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        sr[4*c+r] = sb[4*((c+r)%4)+r];
  end

  // next round key
  always_comb begin
    nk[0] = kb[0] ^ SBOX[kb[13]] ^ rcon_i;
    nk[1] = kb[1] ^ SBOX[kb[14]];
    nk[2] = kb[2] ^ SBOX[kb[15]];
    nk[3] = kb[3] ^ SBOX[kb[12]];
    for (int i = 4; i < 16; i++) nk[i] = kb[i] ^ nk[i-4];
    for (int i = 0; i < 16; i++) key_o[127-8*i -: 8] = nk[i];
  end

  // remask to row masks, mix, add masked key (or plain key on the last round)
  always_comb begin
    for (int c = 0; c < 4; c++)
      mixed[127-32*c -: 32] = mix_col({sr[4*c] ^ mo_i ^ rm_i[31:24],
                                       sr[4*c+1] ^ mo_i ^ rm_i[23:16],
                                       sr[4*c+2] ^ mo_i ^ rm_i[15:8],
                                       sr[4*c+3] ^ mo_i ^ rm_i[7:0]});
    for (int i = 0; i < 16; i++) begin
      if (last_i)
        state_o[127-8*i -: 8] = sr[i] ^ nk[i] ^ mo_i ^ mo_i;
      else
        state_o[127-8*i -: 8] = mixed[127-8*i -: 8] ^ nk[i] ^ cm_i[31-8*(i%4) -: 8] ^ m_i;
    end
  end
endmodule

// File: rtl/masked_aes128_encrypt_unit.sv
// Masked AES-128 encryption unit: one block per transaction.
// Each block is loaded on the input transaction edge, then runs 10 rounds through
// one shared round unit; its result is offered until taken and the unit returns to
// idle before the next block is accepted.
// Not ready while a block is in flight or its result waits.
// Reset (synchronous, active low) returns the sequencer to idle.
module masked_aes128_encrypt_unit import maes_pkg::*; (
  input logic clk,
  input logic rst_n,
  maes_if.sink   in_ch,
  maes_if.source out_ch
);
  state_t state_r, state_nxt;
  logic [ROUND_W-1:0] rnd_r, rnd_nxt;
  logic [127:0] s_r, k_r, s_new, k_new, p, k;
  logic [7:0] rcon_r, m_r, mo_r;
  logic [31:0] rm_r, cm_r, cm_in;
  logic last;

  assign p = in_ch.data[303:176];
  assign k = in_ch.data[175:48];
  assign cm_in = mix_col(in_ch.data[31:0]);
  assign last = (rnd_r == ROUND_W'(NUM_ROUNDS));

  maes_round u_round (
    .state_i(s_r), .key_i(k_r), .rcon_i(rcon_r), .last_i(last),
    .m_i(m_r), .mo_i(mo_r), .rm_i(rm_r), .cm_i(cm_r),
    .state_o(s_new), .key_o(k_new)
  );

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign out_ch.valid = (state_r == ST_DONE);
  assign out_ch.data  = s_r;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    rnd_nxt = rnd_r;
    unique case (state_r)
      ST_IDLE: if (in_ch.valid) begin state_nxt = ST_ROUND; rnd_nxt = ROUND_W'(1); end
      ST_ROUND: begin
        if (last) state_nxt = ST_DONE;
        else rnd_nxt = rnd_r + ROUND_W'(1);
      end
      ST_DONE: if (out_ch.ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rnd_r <= '0;
    end else begin
      state_r <= state_nxt;
      rnd_r <= rnd_nxt;
    end
  end

  // datapath: load masked state, then one round a cycle
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_ch.valid) begin
      for (int i = 0; i < 16; i++)
        s_r[127-8*i -: 8] <= p[127-8*i -: 8] ^ k[127-8*i -: 8] ^ in_ch.data[47:40];
      k_r <= k;
      rcon_r <= RCON_FIRST;
      m_r <= in_ch.data[47:40];
      mo_r <= in_ch.data[39:32];
      rm_r <= in_ch.data[31:0];
      cm_r <= cm_in;
    end else if (state_r == ST_ROUND) begin
      s_r <= last ? (s_new ^ {16{mo_r}}) : s_new;
      k_r <= k_new;
      rcon_r <= gf_dbl(rcon_r);
    end
  end
endmodule

// File: rtl/maes_checker.sv
// Port-level checker for the masked AES-128 unit, bound to the top level.
// The bind below depends on masked_aes128_encrypt_unit.
module maes_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid, in_ready, out_valid, out_ready,
  input logic [127:0] out_data
);
  // no new input while a result is offered
  a_excl: assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !in_ready)
    else $error("input ready while result pending");
  // result holds while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed under stall");
  // an accepted block is not finished next cycle
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid && !in_ready)
    else $error("block finished too early");
endmodule

bind masked_aes128_encrypt_unit maes_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);

// File: tb/masked_aes128_encrypt_unit_tb.sv
// Testbench for the masked AES-128 encryption unit: drives plaintext, key and
// masks, checks each ciphertext against a plain AES-128 model held here.
// Depends on maes_pkg, maes_if and masked_aes128_encrypt_unit.
`timescale 1ns / 100ps

module masked_aes128_encrypt_unit_tb;
  import maes_pkg::*;

  localparam int unsigned IN_W = 304;
  localparam int unsigned OUT_W = 128;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 30;

  typedef struct packed {
    logic [63:0] plain_high;
    logic [63:0] plain_low;
    logic [63:0] key_high;
    logic [63:0] key_low;
    logic [7:0]  sbox_in_mask;
    logic [7:0]  sbox_out_mask;
    logic [7:0]  row0_mask;
    logic [7:0]  row1_mask;
    logic [7:0]  row2_mask;
    logic [7:0]  row3_mask;
  } block_req_t;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
  } cipher_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  maes_if #(.W(IN_W))  in_ch ();
  maes_if #(.W(OUT_W)) out_ch ();

  masked_aes128_encrypt_unit dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  cipher_t     cipher_q[$];
  int unsigned mismatches = 0;
  int unsigned blocks_sent = 0;
  int unsigned blocks_checked = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_left = 0;
  bit          src_gaps = 1'b1;
  bit          sink_gaps = 1'b1;
  int unsigned sink_gap_left = 0;

  always #1 clk = ~clk;

  // GF(2^8) doubling
  function automatic logic [7:0] xtime(input logic [7:0] a);
    return a[7] ? ({a[6:0], 1'b0} ^ GF_POLY) : {a[6:0], 1'b0};
  endfunction

  // Plain AES-128; the masks cancel, so the ciphertext never depends on them
  function automatic cipher_t aes128_cipher(input block_req_t b);
    logic [7:0] st[16], rk[16], tmp[16];
    logic [7:0] rcon, a, bb, c, d;
    logic [127:0] pt, ky, res;
    pt = {b.plain_high, b.plain_low};
    ky = {b.key_high, b.key_low};
    rcon = RCON_FIRST;
    for (int i = 0; i < 16; i++) begin
      st[i] = pt[127-8*i -: 8] ^ ky[127-8*i -: 8];
      rk[i] = ky[127-8*i -: 8];
    end
    for (int r = 1; r <= NUM_ROUNDS; r++) begin
      for (int i = 0; i < 16; i++) tmp[i] = SBOX[st[i]];
      for (int col = 0; col < 4; col++)
        for (int row = 0; row < 4; row++)
          st[4*col+row] = tmp[4*((col+row)%4)+row];
      // advance the round key
      rk[0] ^= SBOX[rk[13]] ^ rcon;
      rk[1] ^= SBOX[rk[14]];
      rk[2] ^= SBOX[rk[15]];
      rk[3] ^= SBOX[rk[12]];
      for (int i = 4; i < 16; i++) rk[i] ^= rk[i-4];
      rcon = xtime(rcon);
      if (r < NUM_ROUNDS) begin
        for (int col = 0; col < 4; col++) begin
          a = st[4*col]; bb = st[4*col+1]; c = st[4*col+2]; d = st[4*col+3];
          st[4*col]   = xtime(a) ^ xtime(bb) ^ bb ^ c ^ d;
          st[4*col+1] = a ^ xtime(bb) ^ xtime(c) ^ c ^ d;
          st[4*col+2] = a ^ bb ^ xtime(c) ^ xtime(d) ^ d;
          st[4*col+3] = xtime(a) ^ a ^ bb ^ c ^ xtime(d);
        end
      end
      for (int i = 0; i < 16; i++) st[i] ^= rk[i];
    end
    for (int i = 0; i < 16; i++) res[127-8*i -: 8] = st[i];
    return res;
  endfunction

  // Offer one block and hold it until the transaction; optionally idle after
  task automatic send_block(input block_req_t b);
    in_ch.valid <= 1'b1;
    in_ch.data  <= b;
    do @(posedge clk); while (!in_ch.ready);
    cipher_q.push_back(aes128_cipher(b));
    blocks_sent++;
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    while (cipher_q.size() != 0) @(posedge clk);
  endtask

  function automatic block_req_t random_block();
    block_req_t b;
    b.plain_high    = {$urandom, $urandom};
    b.plain_low     = {$urandom, $urandom};
    b.key_high      = {$urandom, $urandom};
    b.key_low       = {$urandom, $urandom};
    b.sbox_in_mask  = 8'($urandom);
    b.sbox_out_mask = 8'($urandom);
    b.row0_mask     = 8'($urandom);
    b.row1_mask     = 8'($urandom);
    b.row2_mask     = 8'($urandom);
    b.row3_mask     = 8'($urandom);
    // bias a few fields to all-zero or all-one patterns
    case ($urandom_range(0, 7))
      0: b.plain_high = '0;
      1: b.plain_low = '1;
      2: b.key_high = '1;
      3: begin b.key_low = '0; b.sbox_in_mask = '0; b.sbox_out_mask = '0; end
      4: {b.row0_mask, b.row1_mask, b.row2_mask, b.row3_mask} = '1;
      default: ;
    endcase
    return b;
  endfunction

  task automatic test_directed();
    block_req_t b;
    // known-answer vector, masks off
    b = '0;
    b.plain_high = 64'h0011223344556677; b.plain_low = 64'h8899aabbccddeeff;
    b.key_high   = 64'h0001020304050607; b.key_low   = 64'h08090a0b0c0d0e0f;
    send_block(b);
    // same vector under full masks and under mixed masks
    {b.sbox_in_mask, b.sbox_out_mask, b.row0_mask, b.row1_mask, b.row2_mask,
     b.row3_mask} = '1;
    send_block(b);
    {b.sbox_in_mask, b.sbox_out_mask, b.row0_mask, b.row1_mask, b.row2_mask,
     b.row3_mask} = 48'h5A_A5_01_80_FE_7F;
    send_block(b);
    // equal input and output masks
    b.sbox_in_mask = 8'h3C; b.sbox_out_mask = 8'h3C;
    send_block(b);
    // field extremes
    b = '0;
    send_block(b);
    b = '1;
    send_block(b);
    b = '0; b.plain_high = '1; b.plain_low = '1;
    send_block(b);
    b = '0; b.key_high = '1; b.key_low = '1; b.sbox_out_mask = '1;
    send_block(b);
    b = '1; b.plain_high = '0; b.key_low = '0; b.row2_mask = '0;
    send_block(b);
    for (int i = 0; i < 8; i++) begin
      b = random_block();
      send_block(b);
    end
  endtask

  task automatic test_random(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_block(random_block());
  endtask

  // Receiver holds off while blocks keep coming, so the input stalls
  task automatic test_backpressure();
    hold_left = 150;
    for (int i = 0; i < 6; i++) send_block(random_block());
  endtask

  // Sender waits for every result before each short run
  task automatic test_drain_pause();
    for (int i = 0; i < 5; i++) begin
      in_ch.valid <= 1'b0;
      wait_drained();
      @(posedge clk);
      test_random(4);
    end
  endtask

  // Both sides always ready at full rate
  task automatic test_streaming(input int unsigned n);
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    test_random(n);
  endtask

  // Drive result ready: long hold, random gaps, otherwise ready
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (sink_gap_left != 0) begin
      sink_gap_left <= sink_gap_left - 1;
      out_ch.ready <= 1'b0;
    end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
      sink_gap_left <= $urandom_range(0, 7);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Compare each result transaction with the oldest expected ciphertext
  always @(posedge clk) begin
    cipher_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (cipher_q.size() == 0) begin
        $error("unexpected result transaction: cipher %h", got);
        mismatches++;
      end else begin
        want = cipher_q.pop_front();
        blocks_checked++;
        if (got.cipher_high !== want.cipher_high) begin
          $error("cipher_high expected %h actual %h", want.cipher_high, got.cipher_high);
          mismatches++;
        end
        if (got.cipher_low !== want.cipher_low) begin
          $error("cipher_low expected %h actual %h", want.cipher_low, got.cipher_low);
          mismatches++;
        end
      end
    end
  end

  // Guard against a hang
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, cipher_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(600);
    test_drain_pause();
    test_streaming(250);
    in_ch.valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (cipher_q.size() != 0) mismatches++;
    $display("sent %0d blocks, checked %0d ciphertexts (directed, stalls, streaming)",
             blocks_sent, blocks_checked);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
